[rtl/core/gcms_pkg.sv]
// Shared types, register codes and helpers for the grid cell max select block.
`timescale 1ns / 1ps

package gcms_pkg;

    // Register indexes on the configuration port
    localparam logic [7:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [7:0] REG_IMAGE_HEIGHT = 8'd1;
    localparam logic [7:0] REG_CELL_WIDTH   = 8'd2;
    localparam logic [7:0] REG_CELL_HEIGHT  = 8'd3;

    // Reset geometry, held as effective size minus one
    localparam logic [10:0] RST_WIDTH_M1  = 11'd639;
    localparam logic [10:0] RST_HEIGHT_M1 = 11'd479;
    localparam logic [7:0]  RST_CELL_W_M1 = 8'd31;
    localparam logic [7:0]  RST_CELL_H_M1 = 8'd31;

    // One input item
    typedef struct packed {
        logic        frame_start;
        logic [15:0] gradient;
        logic [7:0]  mask_value;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [10:0] cell_row;
        logic [10:0] cell_column;
        logic        has_candidate;
        logic [10:0] best_row;
        logic [10:0] best_column;
        logic        frame_done;
    } t_out_item;

    // Effective geometry, every size stored minus one
    typedef struct packed {
        logic [10:0] width_m1;
        logic [10:0] height_m1;
        logic [7:0]  cell_w_m1;
        logic [7:0]  cell_h_m1;
    } t_geom;

    // Position of the current pixel and the flags that end its cell
    typedef struct packed {
        logic        first;
        logic        cell_end;
        logic        frame_done;
        logic [10:0] pixel_row;
        logic [10:0] pixel_column;
        logic [10:0] cell_row;
        logic [10:0] cell_column;
    } t_pos;

    // Image size clamped to 1..2048, returned minus one
    function automatic logic [10:0] image_size_m1(input logic [11:0] v);
        logic [10:0] r;
        if (v == 12'd0) begin
            r = 11'd0;
        end else if (v > 12'd2048) begin
            r = 11'd2047;
        end else begin
            r = 11'(v - 12'd1);
        end
        return r;
    endfunction

    // Cell size clamped to 1..256, returned minus one
    function automatic logic [7:0] cell_size_m1(input logic [8:0] v);
        logic [7:0] r;
        if (v == 9'd0) begin
            r = 8'd0;
        end else if (v > 9'd256) begin
            r = 8'd255;
        end else begin
            r = 8'(v - 9'd1);
        end
        return r;
    endfunction

endpackage

[rtl/core/gcms_cfg.sv]
// Configuration registers with the cell column count check.
`timescale 1ns / 1ps

module gcms_cfg #(
    parameter int MAX_CELL_COLUMNS = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [7:0]      i_cfg_index,
    input  logic [11:0]     i_cfg_data,
    output gcms_pkg::t_geom o_geom
);

    gcms_pkg::t_geom r_geom;

    logic [11:0] ew_new, ew_cur;
    logic [8:0]  ec_new, ec_cur;
    logic [20:0] lim_new_cell, lim_cur_cell;
    logic        width_ok, cell_ok;

    assign o_cfg_ready = 1'b1;
    assign o_geom      = r_geom;

    // Effective sizes of the written value and of the current registers
    assign ew_new = 12'(gcms_pkg::image_size_m1(i_cfg_data)) + 12'd1;
    assign ew_cur = 12'(r_geom.width_m1) + 12'd1;
    assign ec_new = 9'(gcms_pkg::cell_size_m1(i_cfg_data[8:0])) + 9'd1;
    assign ec_cur = 9'(r_geom.cell_w_m1) + 9'd1;

    // ceil(w / cw) <= MAX holds exactly when w <= MAX * cw
    assign lim_cur_cell = 21'(MAX_CELL_COLUMNS) * 21'(ec_cur);
    assign lim_new_cell = 21'(MAX_CELL_COLUMNS) * 21'(ec_new);
    assign width_ok     = 21'(ew_new) <= lim_cur_cell;
    assign cell_ok      = 21'(ew_cur) <= lim_new_cell;

    // Register writes; oversized column counts are refused
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.width_m1  <= gcms_pkg::RST_WIDTH_M1;
            r_geom.height_m1 <= gcms_pkg::RST_HEIGHT_M1;
            r_geom.cell_w_m1 <= gcms_pkg::RST_CELL_W_M1;
            r_geom.cell_h_m1 <= gcms_pkg::RST_CELL_H_M1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gcms_pkg::REG_IMAGE_WIDTH: begin
                    if (width_ok) begin
                        r_geom.width_m1 <= gcms_pkg::image_size_m1(i_cfg_data);
                    end
                end
                gcms_pkg::REG_IMAGE_HEIGHT: begin
                    r_geom.height_m1 <= gcms_pkg::image_size_m1(i_cfg_data);
                end
                gcms_pkg::REG_CELL_WIDTH: begin
                    if (cell_ok) begin
                        r_geom.cell_w_m1 <= gcms_pkg::cell_size_m1(i_cfg_data[8:0]);
                    end
                end
                gcms_pkg::REG_CELL_HEIGHT: begin
                    r_geom.cell_h_m1 <= gcms_pkg::cell_size_m1(i_cfg_data[8:0]);
                end
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/core/gcms_scan.sv]
// Raster position counters: pixel, offset within cell and cell indexes.
`timescale 1ns / 1ps

module gcms_scan #(
    parameter int MAX_CELL_COLUMNS = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_frame_start,
    input  gcms_pkg::t_geom i_geom,
    output gcms_pkg::t_pos  o_pos
);

    localparam int CIW = (MAX_CELL_COLUMNS > 1) ? $clog2(MAX_CELL_COLUMNS) : 1;
    localparam logic [CIW-1:0] LAST_CC = CIW'(MAX_CELL_COLUMNS - 1);

    logic [10:0]    r_pix_col, r_pix_row, r_cell_row;
    logic [7:0]     r_off_col, r_off_row;
    logic [CIW-1:0] r_cell_col;

    logic [10:0]    n_pix_col, n_pix_row, n_cell_row;
    logic [7:0]     n_off_col, n_off_row;
    logic [CIW-1:0] n_cell_col;

    logic [10:0]    c_pix_col, c_pix_row, c_cell_row;
    logic [7:0]     c_off_col, c_off_row;
    logic [CIW-1:0] c_cell_col;
    logic           line_end, last_row, col_full, row_full;

    // Frame start restarts every counter for this item
    assign c_pix_col  = i_frame_start ? 11'd0 : r_pix_col;
    assign c_pix_row  = i_frame_start ? 11'd0 : r_pix_row;
    assign c_off_col  = i_frame_start ? 8'd0 : r_off_col;
    assign c_off_row  = i_frame_start ? 8'd0 : r_off_row;
    assign c_cell_col = i_frame_start ? '0 : r_cell_col;
    assign c_cell_row = i_frame_start ? 11'd0 : r_cell_row;

    // End tests use "at or beyond" so stale counters close at once
    assign line_end = c_pix_col >= i_geom.width_m1;
    assign last_row = c_pix_row >= i_geom.height_m1;
    assign col_full = c_off_col >= i_geom.cell_w_m1;
    assign row_full = c_off_row >= i_geom.cell_h_m1;

    assign o_pos.first        = (c_off_col == 8'd0) && (c_off_row == 8'd0);
    assign o_pos.cell_end     = (line_end || col_full) && (last_row || row_full);
    assign o_pos.frame_done   = line_end && last_row;
    assign o_pos.pixel_row    = c_pix_row;
    assign o_pos.pixel_column = c_pix_col;
    assign o_pos.cell_row     = c_cell_row;
    assign o_pos.cell_column  = 11'(c_cell_col);

    // Advance to the next raster position
    always_comb begin
        n_pix_col  = c_pix_col + 11'd1;
        n_pix_row  = c_pix_row;
        n_off_col  = c_off_col + 8'd1;
        n_off_row  = c_off_row;
        n_cell_col = c_cell_col;
        n_cell_row = c_cell_row;
        if (line_end) begin
            n_pix_col  = 11'd0;
            n_off_col  = 8'd0;
            n_cell_col = '0;
            if (last_row) begin
                n_pix_row  = 11'd0;
                n_off_row  = 8'd0;
                n_cell_row = 11'd0;
            end else begin
                n_pix_row = c_pix_row + 11'd1;
                if (row_full) begin
                    n_off_row  = 8'd0;
                    n_cell_row = c_cell_row + 11'd1;
                end else begin
                    n_off_row = c_off_row + 8'd1;
                end
            end
        end else if (col_full) begin
            n_off_col  = 8'd0;
            n_cell_col = (c_cell_col >= LAST_CC) ? '0 : c_cell_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_col  <= 11'd0;
            r_pix_row  <= 11'd0;
            r_off_col  <= 8'd0;
            r_off_row  <= 8'd0;
            r_cell_col <= '0;
            r_cell_row <= 11'd0;
        end else if (i_accept) begin
            r_pix_col  <= n_pix_col;
            r_pix_row  <= n_pix_row;
            r_off_col  <= n_off_col;
            r_off_row  <= n_off_row;
            r_cell_col <= n_cell_col;
            r_cell_row <= n_cell_row;
        end
    end

endmodule

[rtl/core/gcms_cell_acc.sv]
// Per cell column store, running maximum update and output register.
`timescale 1ns / 1ps

module gcms_cell_acc #(
    parameter int MAX_CELL_COLUMNS = 128,
    parameter int GRADIENT_BITS    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [15:0]         i_gradient,
    input  logic                i_candidate,
    input  gcms_pkg::t_pos      i_pos,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gcms_pkg::t_out_item o_out
);

    localparam int CIW = (MAX_CELL_COLUMNS > 1) ? $clog2(MAX_CELL_COLUMNS) : 1;
    localparam int GW  = (GRADIENT_BITS < 16) ? GRADIENT_BITS : 16;

    // Column stores, one entry per cell column
    logic [GW-1:0] r_mem_grad [MAX_CELL_COLUMNS];
    logic [10:0]   r_mem_row  [MAX_CELL_COLUMNS];
    logic [10:0]   r_mem_col  [MAX_CELL_COLUMNS];
    logic          r_mem_any  [MAX_CELL_COLUMNS];

    // Update stage
    logic           r_s1_valid;
    logic [GW-1:0]  r_s1_grad;
    logic           r_s1_cand;
    gcms_pkg::t_pos r_s1_pos;
    logic [GW-1:0]  r_rd_grad;
    logic [10:0]    r_rd_row, r_rd_col;
    logic           r_rd_any;

    gcms_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic [GW-1:0]  n_grad;
    logic [10:0]    n_row, n_col;
    logic           n_any;
    logic [CIW-1:0] s1_idx, rd_idx;
    logic           s1_adv, accept, out_load;

    assign s1_idx     = r_s1_pos.cell_column[CIW-1:0];
    assign rd_idx     = i_pos.cell_column[CIW-1:0];
    assign s1_adv     = r_s1_valid && (!r_s1_pos.cell_end || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;
    assign out_load   = s1_adv && r_s1_pos.cell_end;

    // First pixel of a cell starts fresh, later ones keep the first maximum
    always_comb begin
        if (r_s1_pos.first) begin
            n_grad = r_s1_grad;
            n_row  = r_s1_pos.pixel_row;
            n_col  = r_s1_pos.pixel_column;
            n_any  = r_s1_cand;
        end else begin
            n_any = r_rd_any || r_s1_cand;
            if (r_s1_grad > r_rd_grad) begin
                n_grad = r_s1_grad;
                n_row  = r_s1_pos.pixel_row;
                n_col  = r_s1_pos.pixel_column;
            end else begin
                n_grad = r_rd_grad;
                n_row  = r_rd_row;
                n_col  = r_rd_col;
            end
        end
    end

    // Store write on leaving the update stage
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_mem_grad[s1_idx] <= n_grad;
            r_mem_row[s1_idx]  <= n_row;
            r_mem_col[s1_idx]  <= n_col;
            r_mem_any[s1_idx]  <= n_any;
        end
    end

    // Store read on accept, forwarding the entry written in the same cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_grad <= i_gradient[GW-1:0];
            r_s1_cand <= i_candidate;
            r_s1_pos  <= i_pos;
            if (s1_adv && (s1_idx == rd_idx)) begin
                r_rd_grad <= n_grad;
                r_rd_row  <= n_row;
                r_rd_col  <= n_col;
                r_rd_any  <= n_any;
            end else begin
                r_rd_grad <= r_mem_grad[rd_idx];
                r_rd_row  <= r_mem_row[rd_idx];
                r_rd_col  <= r_mem_col[rd_idx];
                r_rd_any  <= r_mem_any[rd_idx];
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.cell_row      <= r_s1_pos.cell_row;
            r_out.cell_column   <= r_s1_pos.cell_column;
            r_out.has_candidate <= n_any;
            r_out.best_row      <= n_row;
            r_out.best_column   <= n_col;
            r_out.frame_done    <= r_s1_pos.frame_done;
        end
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[rtl/core/grid_cell_max_select.sv]
// Top level of the grid cell max select block.
//
// Pixels enter in raster order on the input channel (i_in_valid/o_in_ready),
// each item carrying frame_start, a gradient and a candidate mask byte.
// The image is cut into cells; when a cell's last pixel is taken, one
// result item leaves on the output channel (o_out_valid/i_out_ready) with
// the cell indexes, the candidate flag, the position of the first greatest
// gradient in the cell and a frame done flag. Other pixels give no item.
// Geometry is written on the configuration channel, always ready; the user
// is to write it only while the block is idle, which the block itself does
// not enforce. Image width or cell width writes giving too many cell columns
// are dropped. A result passes through the update register, then the output
// register, before it can be taken.
// Throughput: one pixel per cycle, set by the column store read-modify-write,
// whose registered read is forwarded from the write of the previous pixel.
// A stalled receiver holds the output register; pixels that end no cell keep
// flowing, but the next cell's last pixel waits in the update stage and input
// ready then drops until the waiting result is taken.
// Reset clears counters and valid flags and restores the default geometry;
// the column stores need no clearing, as each cell writes its entry first.
`timescale 1ns / 1ps

module grid_cell_max_select #(
    parameter int MAX_CELL_COLUMNS = 128,
    parameter int GRADIENT_BITS    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gcms_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gcms_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [11:0]         i_cfg_data
);

    gcms_pkg::t_geom geom;
    gcms_pkg::t_pos  pos;
    logic            in_ready;
    logic            in_accept;
    logic            candidate;

    assign in_accept  = i_in_valid && in_ready;
    assign candidate  = i_in.mask_value != 8'd0;
    assign o_in_ready = in_ready;

    // Geometry registers
    gcms_cfg #(
        .MAX_CELL_COLUMNS(MAX_CELL_COLUMNS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom)
    );

    // Raster position of the incoming pixel
    gcms_scan #(
        .MAX_CELL_COLUMNS(MAX_CELL_COLUMNS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_frame_start (i_in.frame_start),
        .i_geom        (geom),
        .o_pos         (pos)
    );

    // Cell maximum tracking and result output
    gcms_cell_acc #(
        .MAX_CELL_COLUMNS(MAX_CELL_COLUMNS),
        .GRADIENT_BITS   (GRADIENT_BITS)
    ) u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (in_ready),
        .i_gradient  (i_in.gradient),
        .i_candidate (candidate),
        .i_pos       (pos),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

[dv/tb.sv]
// Self-checking testbench for grid_cell_max_select with a per-cell result predictor.
`timescale 1ns / 1ps

module tb;

    localparam int         CELL_COLUMNS   = 128;
    localparam int         PIPE_DEPTH     = 4;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         RANDOM_ITEMS   = 520;
    localparam logic [7:0] REG_UNMAPPED   = 8'd4;

    // Predicts the cell results from accepted pixels and checks the block against them
    class cell_board;
        logic [11:0] img_w, img_h;
        logic [8:0]  cell_w, cell_h;
        logic [10:0] pix_col, pix_row;
        logic [7:0]  off_col, off_row;
        logic [6:0]  cell_col;
        logic [10:0] cell_row;
        logic [15:0] best_grad [CELL_COLUMNS];
        logic [10:0] best_r [CELL_COLUMNS];
        logic [10:0] best_c [CELL_COLUMNS];
        bit          any_cand [CELL_COLUMNS];
        bit          written [CELL_COLUMNS];
        gcms_pkg::t_out_item cells_due [$];
        int          errors;

        function new();
            img_w    = 12'd640;
            img_h    = 12'd480;
            cell_w   = 9'd32;
            cell_h   = 9'd32;
            pix_col  = '0;
            pix_row  = '0;
            off_col  = '0;
            off_row  = '0;
            cell_col = '0;
            cell_row = '0;
            errors   = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function int clamp(int v, int hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        // Width/cell-width pair must not give more cell columns than the store holds
        function bit columns_fit(int w, int cw);
            int ew;
            int ec;
            ew = clamp(w, 2048);
            ec = clamp(cw, 256);
            return (ew + ec - 1) / ec <= CELL_COLUMNS;
        endfunction

        function void write_reg(logic [7:0] idx, logic [11:0] data);
            case (idx)
                gcms_pkg::REG_IMAGE_WIDTH: begin
                    if (columns_fit(int'(data), int'(cell_w))) img_w = data;
                end
                gcms_pkg::REG_IMAGE_HEIGHT: begin
                    img_h = data;
                end
                gcms_pkg::REG_CELL_WIDTH: begin
                    if (columns_fit(int'(img_w), int'(data[8:0]))) cell_w = data[8:0];
                end
                gcms_pkg::REG_CELL_HEIGHT: begin
                    cell_h = data[8:0];
                end
                default: begin
                end
            endcase
        endfunction

        // Next pixel without frame_start would continue a cell in an entry never filled
        function bit must_restart();
            return (off_col != 8'd0 || off_row != 8'd0) && !written[cell_col];
        endfunction

        function int pending();
            return cells_due.size();
        endfunction

        function void take_pixel(gcms_pkg::t_in_item px);
            int        w, h, cw, chh;
            logic [6:0] c;
            bit        cand, line_end, last_row, col_end, row_end;
            gcms_pkg::t_out_item res;

            w   = clamp(int'(img_w), 2048);
            h   = clamp(int'(img_h), 2048);
            cw  = clamp(int'(cell_w), 256);
            chh = clamp(int'(cell_h), 256);
            cand = px.mask_value != 8'd0;

            if (px.frame_start) begin
                pix_col  = '0;
                pix_row  = '0;
                off_col  = '0;
                off_row  = '0;
                cell_col = '0;
                cell_row = '0;
            end

            // First pixel of a cell opens its entry, later ones update it
            c = cell_col;
            if (off_col == 8'd0 && off_row == 8'd0) begin
                best_grad[c] = px.gradient;
                best_r[c]    = pix_row;
                best_c[c]    = pix_col;
                any_cand[c]  = cand;
                written[c]   = 1'b1;
            end else begin
                if (cand) any_cand[c] = 1'b1;
                if (px.gradient > best_grad[c]) begin
                    best_grad[c] = px.gradient;
                    best_r[c]    = pix_row;
                    best_c[c]    = pix_col;
                end
            end

            line_end = int'(pix_col) >= w - 1;
            last_row = int'(pix_row) >= h - 1;
            col_end  = line_end || int'(off_col) >= cw - 1;
            row_end  = last_row || int'(off_row) >= chh - 1;

            if (col_end && row_end) begin
                res.cell_row      = cell_row;
                res.cell_column   = 11'(cell_col);
                res.has_candidate = any_cand[c];
                res.best_row      = best_r[c];
                res.best_column   = best_c[c];
                res.frame_done    = line_end && last_row;
                cells_due.push_back(res);
            end

            // Advance the raster and cell counters
            if (line_end) begin
                pix_col  = '0;
                off_col  = '0;
                cell_col = '0;
                if (last_row) begin
                    pix_row  = '0;
                    off_row  = '0;
                    cell_row = '0;
                end else begin
                    pix_row = pix_row + 11'd1;
                    if (int'(off_row) >= chh - 1) begin
                        off_row  = '0;
                        cell_row = cell_row + 11'd1;
                    end else begin
                        off_row = off_row + 8'd1;
                    end
                end
            end else begin
                pix_col = pix_col + 11'd1;
                if (int'(off_col) >= cw - 1) begin
                    off_col  = '0;
                    cell_col = cell_col + 7'd1;   // wraps at the store depth
                end else begin
                    off_col = off_col + 8'd1;
                end
            end
        endfunction

        task report(string msg);
            $display("%0t ERROR: %s", $time, msg);
            errors++;
        endtask

        task cmp(string field, int got, int want);
            if (got != want) report($sformatf("%s: got %0d, expected %0d", field, got, want));
        endtask

        task check_cell(gcms_pkg::t_out_item got);
            gcms_pkg::t_out_item want;
            if (cells_due.size() == 0) begin
                report($sformatf("unexpected cell result row %0d column %0d",
                                 got.cell_row, got.cell_column));
                return;
            end
            want = cells_due.pop_front();
            cmp("cell_row", int'(got.cell_row), int'(want.cell_row));
            cmp("cell_column", int'(got.cell_column), int'(want.cell_column));
            cmp("has_candidate", int'(got.has_candidate), int'(want.has_candidate));
            cmp("best_row", int'(got.best_row), int'(want.best_row));
            cmp("best_column", int'(got.best_column), int'(want.best_column));
            cmp("frame_done", int'(got.frame_done), int'(want.frame_done));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    gcms_pkg::t_in_item  in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    gcms_pkg::t_out_item out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [7:0]          cfg_index = gcms_pkg::REG_IMAGE_WIDTH;
    logic [11:0]         cfg_data = '0;

    cell_board sb;
    bit        calm = 1'b0;
    int        idle_cycles = 0;

    grid_cell_max_select uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic logic [15:0] rand_grad();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(0, 3));    // ties are common
            5: return 16'h8000 | 16'($urandom_range(0, 7));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_mask();
        case ($urandom_range(0, 9))
            0: return 8'hFF;
            1: return 8'h01;
            2: return 8'($urandom);
            default: return 8'h00;
        endcase
    endfunction

    // Mostly small sizes, sometimes anything the register field can hold
    function automatic logic [11:0] pick_size(int typical);
        case ($urandom_range(0, 9))
            0: return 12'($urandom_range(0, 4095));
            1: return 12'd1;
            default: return 12'($urandom_range(1, typical));
        endcase
    endfunction

    task automatic send_pixel(bit fs, logic [15:0] grad, logic [7:0] mask);
        gcms_pkg::t_in_item px;
        int       gap;
        px.frame_start = fs | sb.must_restart();
        px.gradient    = grad;
        px.mask_value  = mask;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= px;
        do @(posedge clk); while (!(in_valid && in_ready));
        sb.take_pixel(px);
    endtask

    task automatic cfg_write(logic [7:0] idx, logic [11:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every predicted cell is out and the pipe is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    // Receiver: random stall before each result, none while calm
    initial begin
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // Result check and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) sb.check_cell(out_item);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no progress", $time);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        logic [15:0] dir_grad [15];
        logic [7:0]  dir_mask [15];
        int          rand_items;
        int          n;
        bit          restart;

        dir_grad = '{16'd0, 16'd0, 16'd7, 16'hFFFF, 16'd5,
                     16'd3, 16'd3, 16'd7, 16'hFFFF, 16'd5,
                     16'd9, 16'd9, 16'd0, 16'd0, 16'd1};
        dir_mask = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h00,
                     8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                     8'h00, 8'h80, 8'h00, 8'h00, 8'h00};
        sb = new();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: no cell completes in a few pixels
        send_pixel(1'b1, 16'h0000, 8'h00);
        send_pixel(1'b0, 16'hFFFF, 8'hFF);
        send_pixel(1'b0, 16'h1234, 8'h01);
        settle();

        // 5x3 image in 2x2 cells: partial cells right and bottom, ties, empty cells
        cfg_write(gcms_pkg::REG_IMAGE_WIDTH, 12'd5);
        cfg_write(gcms_pkg::REG_IMAGE_HEIGHT, 12'd3);
        cfg_write(gcms_pkg::REG_CELL_WIDTH, 12'd2);
        cfg_write(gcms_pkg::REG_CELL_HEIGHT, 12'd2);
        for (int i = 0; i < 15; i++) send_pixel(i == 0, dir_grad[i], dir_mask[i]);
        // restart in the middle of a frame
        send_pixel(1'b0, 16'd4, 8'h00);
        send_pixel(1'b0, 16'd2, 8'h00);
        send_pixel(1'b1, 16'd1, 8'h00);
        send_pixel(1'b0, 16'd1, 8'hFF);
        settle();

        // Zero sizes clamp to one: every pixel is a whole frame
        cfg_write(gcms_pkg::REG_IMAGE_WIDTH, 12'd0);
        cfg_write(gcms_pkg::REG_IMAGE_HEIGHT, 12'd0);
        cfg_write(gcms_pkg::REG_CELL_WIDTH, 12'd0);
        cfg_write(gcms_pkg::REG_CELL_HEIGHT, 12'd0);
        send_pixel(1'b1, 16'hFFFF, 8'h00);
        send_pixel(1'b0, 16'h0000, 8'hFF);
        settle();

        // Oversized values clamp; writes giving too many cell columns are dropped
        cfg_write(gcms_pkg::REG_IMAGE_WIDTH, 12'hFFF);
        cfg_write(gcms_pkg::REG_CELL_WIDTH, 12'hFFF);
        cfg_write(gcms_pkg::REG_IMAGE_WIDTH, 12'hFFF);
        cfg_write(gcms_pkg::REG_CELL_WIDTH, 12'd8);
        cfg_write(gcms_pkg::REG_CELL_WIDTH, 12'd16);
        cfg_write(gcms_pkg::REG_CELL_HEIGHT, 12'hFFF);
        cfg_write(REG_UNMAPPED, 12'h5A5);
        calm = 1'b1;
        for (int i = 0; i < 40; i++) send_pixel(i == 0, rand_grad(), rand_mask());
        settle();

        // Full row of the widest cell column count
        cfg_write(gcms_pkg::REG_IMAGE_WIDTH, 12'd256);
        cfg_write(gcms_pkg::REG_CELL_WIDTH, 12'd2);
        for (int i = 0; i < 256; i++) send_pixel(i == 0, rand_grad(), rand_mask());
        settle();

        // Tallest image, one-pixel cells
        cfg_write(gcms_pkg::REG_IMAGE_HEIGHT, 12'd2048);
        cfg_write(gcms_pkg::REG_IMAGE_WIDTH, 12'd1);
        cfg_write(gcms_pkg::REG_CELL_WIDTH, 12'd1);
        cfg_write(gcms_pkg::REG_CELL_HEIGHT, 12'd1);
        for (int i = 0; i < 60; i++) send_pixel(i == 0, rand_grad(), rand_mask());
        calm = 1'b0;

        // Random geometries; some phases carry on mid-frame into the new sizes
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            settle();
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0) cfg_write(gcms_pkg::REG_IMAGE_WIDTH, pick_size(24));
            if ($urandom_range(0, 3) != 0) cfg_write(gcms_pkg::REG_IMAGE_HEIGHT, pick_size(10));
            if ($urandom_range(0, 3) != 0) cfg_write(gcms_pkg::REG_CELL_WIDTH, pick_size(8));
            if ($urandom_range(0, 3) != 0) cfg_write(gcms_pkg::REG_CELL_HEIGHT, pick_size(6));
            restart = ($urandom_range(0, 4) != 0);
            n = $urandom_range(20, 120);
            for (int i = 0; i < n; i++) begin
                send_pixel(i == 0 ? restart : ($urandom_range(0, 80) == 0),
                           rand_grad(), rand_mask());
                rand_items++;
                if ($urandom_range(0, 150) == 0) settle();
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (sb.pending() != 0) sb.report($sformatf("%0d cell results never came", sb.pending()));
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
